/* hdl/mandelbrot_escape_time_core_macros.svh */
// Assertion macros shared by the escape-time core modules.
`ifndef MANDELBROT_ESCAPE_TIME_CORE_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MET_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MET_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/met_pkg.sv */
// Shared types and constants for the escape-time core.
package met_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int SUM_W      = 41;

    localparam logic [CFG_IDX_W-1:0] REG_REAL_ORIGIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAG_ORIGIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REAL_STEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAG_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT  = 3'd4;

    localparam logic signed [31:0] RST_REAL_ORIGIN = -32'sd536870912;
    localparam logic signed [31:0] RST_IMAG_ORIGIN = 32'sd402653184;
    localparam logic [30:0]        RST_REAL_STEP   = 31'd268467;
    localparam logic [30:0]        RST_IMAG_STEP   = 31'd268467;
    localparam logic [15:0]        RST_ITER_LIMIT  = 16'd1000;

    localparam logic [SUM_W-1:0]   SUM_MAX = {SUM_W{1'b1}};

    typedef struct packed {
        logic [11:0] column;
        logic [11:0] row;
        logic        frame_start;
    } t_met_pixel;

    typedef struct packed {
        logic [15:0]      iteration_count;
        logic [7:0]       gray_level;
        logic [SUM_W-1:0] count_sum;
        logic [15:0]      count_min;
        logic [15:0]      count_max;
    } t_met_result;

    typedef struct packed {
        logic load;
        logic map;
        logic mul;
        logic update;
        logic div_start;
        logic push;
    } t_met_cmd;

    typedef struct packed {
        logic limit_hit;
        logic escape;
        logic div_done;
        logic out_free;
    } t_met_sts;

endpackage

/* hdl/met_div.sv */
// Restoring divider for the gray level: 8 quotient bits, one per cycle.
module met_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [23:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [7:0]  o_quotient
);

    logic        r_busy;
    logic        r_done;
    logic [2:0]  r_step;
    logic [23:0] r_rem;
    logic [15:0] r_div;
    logic [7:0]  r_quot;
    logic [23:0] w_trial;
    logic        w_take;

    // Quotient is known to stay below 256 since the count never exceeds the limit.
    assign w_trial = {8'b0, r_div} << r_step;
    assign w_take  = (r_div != 16'd0) && (r_rem >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == 3'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend;
            r_div  <= i_divisor;
            r_quot <= 8'd0;
            r_step <= 3'd7;
        end else if (r_busy) begin
            if (w_take) begin
                r_rem <= r_rem - w_trial;
            end
            r_quot[r_step] <= w_take;
            r_step         <= r_step - 3'd1;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quot;

endmodule

/* hdl/met_dp.sv */
// Datapath: config registers, point mapping, z iteration, gray divide, frame statistics.
`include "mandelbrot_escape_time_core_macros.svh"

module met_dp #(
    parameter int MAX_COLUMNS   = 4096,
    parameter int MAX_ROWS      = 4096,
    parameter int FRACTION_BITS = 28
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [met_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [met_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  met_pkg::t_met_pixel             i_pix,
    input  logic                            i_res_stall,
    input  met_pkg::t_met_cmd               i_cmd,
    output met_pkg::t_met_sts               o_sts,
    output logic                            o_res_valid,
    output met_pkg::t_met_result            o_res
);

    localparam logic [16:0] COL_LAST = 17'(MAX_COLUMNS - 1);
    localparam logic [16:0] ROW_LAST = 17'(MAX_ROWS - 1);
    localparam logic [64:0] BOUND    = 65'(4) << FRACTION_BITS;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] res;
        if (v > 66'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -66'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // configuration
    logic signed [31:0] r_real_origin;
    logic signed [31:0] r_imag_origin;
    logic [30:0]        r_real_step;
    logic [30:0]        r_imag_step;
    logic [15:0]        r_limit;

    // pixel and iteration state
    logic [42:0]        r_prod_re;
    logic [42:0]        r_prod_im;
    logic               r_fs;
    logic signed [31:0] r_cr;
    logic signed [31:0] r_ci;
    logic signed [31:0] r_zr;
    logic signed [31:0] r_zi;
    logic signed [63:0] r_sq_re;
    logic signed [63:0] r_sq_im;
    logic signed [63:0] r_cross;
    logic [15:0]        r_count;

    // statistics and output
    logic [met_pkg::SUM_W-1:0] r_sum;
    logic [15:0]               r_min;
    logic [15:0]               r_max;
    logic                      r_out_valid;
    met_pkg::t_met_result      r_out;

    logic [11:0]               w_col;
    logic [11:0]               w_row;
    logic signed [44:0]        w_cr_full;
    logic signed [44:0]        w_ci_full;
    logic [64:0]               w_rr;
    logic [64:0]               w_ii;
    logic [64:0]               w_mag;
    logic signed [65:0]        w_nr;
    logic signed [63:0]        w_xs;
    logic signed [65:0]        w_ni;
    logic [23:0]               w_dividend;
    logic                      w_div_done;
    logic [7:0]                w_quot;
    logic [met_pkg::SUM_W-1:0] w_base_sum;
    logic [15:0]               w_base_min;
    logic [15:0]               w_base_max;
    logic [met_pkg::SUM_W:0]   w_sum_ext;
    logic [met_pkg::SUM_W-1:0] w_new_sum;
    logic [15:0]               w_new_min;
    logic [15:0]               w_new_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_real_origin <= met_pkg::RST_REAL_ORIGIN;
            r_imag_origin <= met_pkg::RST_IMAG_ORIGIN;
            r_real_step   <= met_pkg::RST_REAL_STEP;
            r_imag_step   <= met_pkg::RST_IMAG_STEP;
            r_limit       <= met_pkg::RST_ITER_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                met_pkg::REG_REAL_ORIGIN: r_real_origin <= i_cfg_data;
                met_pkg::REG_IMAG_ORIGIN: r_imag_origin <= i_cfg_data;
                met_pkg::REG_REAL_STEP:   r_real_step   <= i_cfg_data[30:0];
                met_pkg::REG_IMAG_STEP:   r_imag_step   <= i_cfg_data[30:0];
                met_pkg::REG_ITER_LIMIT:  r_limit       <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // clamp coordinates to the frame
    always_comb begin
        w_col = i_pix.column;
        w_row = i_pix.row;
        if ({5'b0, i_pix.column} > COL_LAST) begin
            w_col = COL_LAST[11:0];
        end
        if ({5'b0, i_pix.row} > ROW_LAST) begin
            w_row = ROW_LAST[11:0];
        end
    end

    assign w_cr_full = 45'(r_real_origin) + $signed({2'b00, r_prod_re});
    assign w_ci_full = 45'(r_imag_origin) - $signed({2'b00, r_prod_im});

    // squares are never negative, so a logical shift is the floor
    assign w_rr  = {1'b0, r_sq_re} >> FRACTION_BITS;
    assign w_ii  = {1'b0, r_sq_im} >> FRACTION_BITS;
    assign w_mag = w_rr + w_ii;
    assign w_nr  = $signed({1'b0, w_rr}) - $signed({1'b0, w_ii}) + 66'(r_cr);
    assign w_xs  = r_cross >>> (FRACTION_BITS - 1);
    assign w_ni  = 66'(w_xs) + 66'(r_ci);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_prod_re <= 43'(w_col) * 43'(r_real_step);
            r_prod_im <= 43'(w_row) * 43'(r_imag_step);
            r_fs      <= i_pix.frame_start;
        end
        if (i_cmd.map) begin
            r_cr    <= sat32(66'(w_cr_full));
            r_ci    <= sat32(66'(w_ci_full));
            r_zr    <= 32'sd0;
            r_zi    <= 32'sd0;
            r_count <= 16'd0;
        end
        if (i_cmd.mul) begin
            r_sq_re <= r_zr * r_zr;
            r_sq_im <= r_zi * r_zi;
            r_cross <= r_zr * r_zi;
        end
        if (i_cmd.update) begin
            r_zr    <= sat32(w_nr);
            r_zi    <= sat32(w_ni);
            r_count <= r_count + 16'd1;
        end
    end

    // 255 * count without a multiplier
    assign w_dividend = {r_count, 8'b0} - 24'(r_count);

    met_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_limit),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // frame start drops the old statistics before this pixel counts
    assign w_base_sum = r_fs ? '0 : r_sum;
    assign w_base_min = r_fs ? 16'hFFFF : r_min;
    assign w_base_max = r_fs ? 16'd0 : r_max;
    assign w_sum_ext  = {1'b0, w_base_sum} + (met_pkg::SUM_W + 1)'(r_count);
    assign w_new_sum  = w_sum_ext[met_pkg::SUM_W] ? met_pkg::SUM_MAX
                                                  : w_sum_ext[met_pkg::SUM_W-1:0];
    assign w_new_min  = (r_count < w_base_min) ? r_count : w_base_min;
    assign w_new_max  = (r_count > w_base_max) ? r_count : w_base_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_min       <= 16'hFFFF;
            r_max       <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_sum       <= w_new_sum;
                r_min       <= w_new_min;
                r_max       <= w_new_max;
                r_out_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out.iteration_count <= r_count;
            r_out.gray_level      <= w_quot;
            r_out.count_sum       <= w_new_sum;
            r_out.count_min       <= w_new_min;
            r_out.count_max       <= w_new_max;
        end
    end

    assign o_sts.limit_hit = (r_count >= r_limit);
    assign o_sts.escape    = (w_mag > BOUND);
    assign o_sts.div_done  = w_div_done;
    assign o_sts.out_free  = !r_out_valid || !i_res_stall;
    assign o_res_valid     = r_out_valid;
    assign o_res           = r_out;

    `MET_ASSERT_NXT(a_push_valid, i_clk, i_rst_n, i_cmd.push, r_out_valid, "push lost its beat")
    `MET_ASSERT_NXT(a_count_le_limit, i_clk, i_rst_n, i_cmd.update, r_count <= r_limit, "count passed limit")
    `MET_ASSERT_IMP(a_stats_order, i_clk, i_rst_n, r_out_valid, (r_out.count_min <= r_out.iteration_count) && (r_out.iteration_count <= r_out.count_max), "statistics exclude count")

endmodule

/* hdl/met_ctrl.sv */
// Controller state machine sequencing one pixel through the datapath.
`include "mandelbrot_escape_time_core_macros.svh"

module met_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_pix_valid,
    output logic              o_pix_stall,
    input  met_pkg::t_met_sts i_sts,
    output met_pkg::t_met_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MAP  = 6'b000010,
        S_MUL  = 6'b000100,
        S_TST  = 6'b001000,
        S_DIV  = 6'b010000,
        S_PUSH = 6'b100000
    } t_met_state;

    t_met_state r_state;
    t_met_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_pix_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MAP;
                end
            end
            S_MAP: begin
                o_cmd.map = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                if (i_sts.limit_hit) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_TST;
                end
            end
            S_TST: begin
                if (i_sts.escape) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    o_cmd.update = 1'b1;
                    n_state      = S_MUL;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                // hold until the output register can take the beat
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_pix_stall = (r_state != S_IDLE);

    `MET_ASSERT_NXT(a_accept_map, i_clk, i_rst_n, i_pix_valid && !o_pix_stall, r_state == S_MAP, "accepted beat not mapped")
    `MET_ASSERT_IMP(a_push_free, i_clk, i_rst_n, o_cmd.push, i_sts.out_free, "push over a waiting result")
    `MET_ASSERT_NXT(a_div_wait, i_clk, i_rst_n, o_cmd.div_start, r_state == S_DIV, "divide start without wait")

endmodule

/* hdl/mandelbrot_escape_time_core.sv */
// Mandelbrot escape-time core: takes one pixel beat, maps it to the point c in
// signed fixed point, iterates z = z*z + c until |z|^2 > 4 or the iteration limit,
// then returns the count, the gray level 255*count/limit and the running frame sum,
// minimum and maximum. One pixel is in flight at a time. Each iteration passes
// through the three registered 32x32 multipliers and then through the shift,
// compare, add and saturate stage. The gray level comes from a restoring
// divider. A finished result waits in the output register while the next pixel
// is accepted. Configuration is written through a plain write port; the user
// must write it only while the core is idle, which the core does not enforce.
module mandelbrot_escape_time_core #(
    parameter int MAX_COLUMNS   = 4096,
    parameter int MAX_ROWS      = 4096,
    parameter int FRACTION_BITS = 28
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [met_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [met_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_pix_valid,
    output logic                            o_pix_stall,
    input  met_pkg::t_met_pixel             i_pix,
    output logic                            o_res_valid,
    input  logic                            i_res_stall,
    output met_pkg::t_met_result            o_res
);

    met_pkg::t_met_cmd w_cmd;
    met_pkg::t_met_sts w_sts;

    met_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (i_pix_valid),
        .o_pix_stall (o_pix_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    met_dp #(
        .MAX_COLUMNS   (MAX_COLUMNS),
        .MAX_ROWS      (MAX_ROWS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (i_pix),
        .i_res_stall (i_res_stall),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule
